// ----- src/bfha_pkg.sv -----
`timescale 1ns / 1ps
package bfha_pkg;
    localparam int unsigned ADDR_W = 24;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NULL      = 2'd1,
        ST_NO_MEMORY = 2'd2,
        ST_UNKNOWN   = 2'd3
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // classified command handed from front to back
    typedef struct packed {
        logic              op;
        logic              trivial;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] address;
    } bfha_cmd_t;
endpackage

// ----- src/bfha_ram.sv -----
`timescale 1ns / 1ps
module bfha_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/bfha_front.sv -----
`timescale 1ns / 1ps
module bfha_front import bfha_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [ADDR_W-1:0] request_bytes,
    input  logic [ADDR_W-1:0] address,
    output logic              q_valid,
    output bfha_cmd_t         q_cmd,
    input  logic              q_pop,
    input  logic              back_idle
);
    // two-entry queue between front and back
    bfha_cmd_t  q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       push;
    bfha_cmd_t  cmd_in;

    // one item in flight at a time across front, queue and back
    assign busy = (cnt_reg != 2'd0) || !back_idle;
    assign push = start && !busy;

    always_comb
    begin
        cmd_in.op = op;
        cmd_in.request_bytes = request_bytes;
        cmd_in.address = address;
        cmd_in.trivial = (op == OP_ALLOC) ? (request_bytes == '0) : (address == '0);
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd = q_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_reg[rd_reg ^ cnt_reg[0]] <= cmd_in;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ----- src/bfha_back.sv -----
`timescale 1ns / 1ps
module bfha_back import bfha_pkg::*; #(
    parameter int unsigned MAX_SEGMENTS = 64,
    parameter int unsigned HEADER_BYTES = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] pool_bytes,
    input  logic              q_valid,
    input  bfha_cmd_t         q_cmd,
    output logic              q_pop,
    output logic              idle,
    output logic              done,
    output logic [ADDR_W-1:0] payload_address,
    output logic [STATUS_W-1:0] status
);
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = IW + 1;
    localparam int unsigned EW = 2 * ADDR_W + 1;
    localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_ALLOC, S_SHIFT_RD, S_SHIFT_WR,
        S_SPLIT, S_MERGE_RD, S_MERGE, S_REMOVE_RD, S_REMOVE_WR, S_DONE
    } state_t;

    state_t            state_reg;
    bfha_cmd_t         cmd_reg;
    logic [CW-1:0]     count_reg;
    logic              ready_reg;
    logic [CW-1:0]     i_reg;
    logic              found_reg;
    logic [IW-1:0]     best_reg;
    logic [ADDR_W-1:0] bstart_reg;
    logic [ADDR_W-1:0] bsize_reg;
    logic [EW-1:0]     prev_reg;
    logic              done_reg;
    logic [ADDR_W-1:0] addr_out_reg;
    logic [STATUS_W-1:0] status_reg;

    logic              we;
    logic [IW-1:0]     waddr, raddr;
    logic [EW-1:0]     wdata, rdata;
    logic [ADDR_W-1:0] r_start, r_size;
    logic              r_free;

    assign {r_start, r_size, r_free} = rdata;

    bfha_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [ADDR_W:0] need;
    assign need = {1'b0, cmd_reg.request_bytes} + {1'b0, HDR};

    always_comb
    begin
        we = 1'b0;
        waddr = i_reg[IW-1:0];
        wdata = prev_reg;
        raddr = i_reg[IW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                // lazy pool set-up
                if (q_valid && q_cmd.op == OP_ALLOC && !q_cmd.trivial && !ready_reg)
                begin
                    we = 1'b1;
                    waddr = '0;
                    wdata = {{ADDR_W{1'b0}},
                             (pool_bytes > HDR) ? pool_bytes - HDR : {ADDR_W{1'b0}}, 1'b1};
                end
            end
            S_ALLOC:
            begin
                // only a successful allocate marks its segment
                if (cmd_reg.op == OP_ALLOC && found_reg)
                begin
                    we = 1'b1;
                    waddr = best_reg;
                    wdata = {bstart_reg,
                             (bsize_reg > need[ADDR_W-1:0] && !need[ADDR_W] && count_reg < MAXC)
                                ? cmd_reg.request_bytes : bsize_reg, 1'b0};
                end
            end
            S_SHIFT_RD: raddr = IW'(i_reg - 1'b1);
            S_SHIFT_WR:
            begin
                we = 1'b1;
                wdata = rdata;
            end
            S_SPLIT:
            begin
                we = 1'b1;
                wdata = {bstart_reg + need[ADDR_W-1:0],
                         bsize_reg - need[ADDR_W-1:0], 1'b1};
            end
            S_MERGE:
            begin
                // mark freed entry, or fold a free pair into entry i-1
                if (found_reg && i_reg[IW-1:0] == best_reg)
                begin
                    we = 1'b1;
                    wdata = {r_start, r_size, 1'b1};
                end
                else if (i_reg != '0 && prev_reg[0] && r_free)
                begin
                    we = 1'b1;
                    waddr = IW'(i_reg - 1'b1);
                    wdata = {prev_reg[EW-1 -: ADDR_W],
                             prev_reg[ADDR_W:1] + HDR + r_size, 1'b1};
                end
            end
            S_REMOVE_RD: raddr = IW'(i_reg + 1'b1);
            S_REMOVE_WR:
            begin
                we = 1'b1;
                wdata = rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ready_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        i_reg <= '0;
                        found_reg <= 1'b0;
                        addr_out_reg <= '0;
                        if (q_cmd.trivial)
                        begin
                            status_reg <= ST_NULL;
                            state_reg <= S_DONE;
                        end
                        else if (q_cmd.op == OP_FREE && !ready_reg)
                        begin
                            status_reg <= ST_UNKNOWN;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            if (q_cmd.op == OP_ALLOC && !ready_reg)
                            begin
                                ready_reg <= 1'b1;
                                count_reg <= CW'(1);
                            end
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (cmd_reg.op == OP_ALLOC)
                    begin
                        if (r_free && r_size >= cmd_reg.request_bytes
                            && (!found_reg || r_size < bsize_reg))
                        begin
                            found_reg <= 1'b1;
                            best_reg <= i_reg[IW-1:0];
                            bstart_reg <= r_start;
                            bsize_reg <= r_size;
                        end
                    end
                    else if (!found_reg && !r_free && r_start + HDR == cmd_reg.address)
                    begin
                        found_reg <= 1'b1;
                        best_reg <= i_reg[IW-1:0];
                    end
                    if (i_reg + 1'b1 < count_reg)
                    begin
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        state_reg <= S_ALLOC;
                    end
                end
                S_ALLOC:
                begin
                    if (cmd_reg.op == OP_FREE)
                    begin
                        if (found_reg)
                        begin
                            status_reg <= ST_OK;
                            i_reg <= '0;
                            state_reg <= S_MERGE_RD;
                        end
                        else
                        begin
                            status_reg <= ST_UNKNOWN;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (!found_reg)
                    begin
                        status_reg <= ST_NO_MEMORY;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        addr_out_reg <= bstart_reg + HDR;
                        if (bsize_reg > need[ADDR_W-1:0] && !need[ADDR_W] && count_reg < MAXC)
                        begin
                            i_reg <= count_reg;
                            state_reg <= S_SHIFT_RD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SHIFT_RD:
                begin
                    if (i_reg == CW'(best_reg) + 1'b1)
                    begin
                        state_reg <= S_SPLIT;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    prev_reg <= rdata;
                    i_reg <= i_reg - 1'b1;
                    state_reg <= S_SHIFT_RD;
                end
                S_SPLIT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_MERGE_RD:
                begin
                    if (i_reg < count_reg)
                    begin
                        state_reg <= S_MERGE;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_MERGE:
                begin
                    if (found_reg && i_reg[IW-1:0] == best_reg)
                    begin
                        // re-read with free flag set
                        found_reg <= 1'b0;
                        state_reg <= S_MERGE_RD;
                    end
                    else if (i_reg != '0 && prev_reg[0] && r_free)
                    begin
                        prev_reg <= {prev_reg[EW-1 -: ADDR_W],
                                     prev_reg[ADDR_W:1] + HDR + r_size, 1'b1};
                        state_reg <= S_REMOVE_RD;
                    end
                    else
                    begin
                        prev_reg <= rdata;
                        i_reg <= i_reg + 1'b1;
                        state_reg <= S_MERGE_RD;
                    end
                end
                S_REMOVE_RD:
                begin
                    if (i_reg + 1'b1 < count_reg)
                    begin
                        state_reg <= S_REMOVE_WR;
                    end
                    else
                    begin
                        // removal done; restart at the merged entry's successor
                        count_reg <= count_reg - 1'b1;
                        i_reg <= cmd_reg.request_bytes[CW-1:0];
                        state_reg <= S_MERGE_RD;
                    end
                end
                S_REMOVE_WR:
                begin
                    i_reg <= i_reg + 1'b1;
                    state_reg <= S_REMOVE_RD;
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            // remember where removal began (merge target index + 1)
            if (state_reg == S_MERGE && !(found_reg && i_reg[IW-1:0] == best_reg)
                && i_reg != '0 && prev_reg[0] && r_free)
            begin
                cmd_reg.request_bytes <= ADDR_W'(i_reg);
            end
        end
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign idle = (state_reg == S_IDLE) && !done_reg;
    assign done = done_reg;
    assign payload_address = addr_out_reg;
    assign status = status_reg;
endmodule

// ----- src/best_fit_heap_allocator_core.sv -----
`timescale 1ns / 1ps
// best-fit allocator over one pool with split and coalesce
// command channel: start/busy; an item transfers when start is high and busy low
//   op 0 allocates request_bytes, op 1 frees the payload at address
// result: done strobes one cycle with payload_address and status
//   (0 ok, 1 null ignored, 2 out of memory, 3 unknown address)
// the receiver cannot stall; every result is taken the cycle it is shown
// config: cfg_valid/cfg_ready write pool_bytes, sampled at first allocate
// operation: each scan reads every table entry in turn; a split then
//   shifts each entry above the best fit up by one, and a free adds a second
//   pass over the table plus a shift down of the entries on each merge
// a full table holds MAX_SEGMENTS entries, 64 by default; the entries are
//   read one at a time through the single read port of the segment table
// one item in flight at a time; busy stays high until its result is out
// reset empties the table; the pool is set up on the first nonzero allocate
module best_fit_heap_allocator_core import bfha_pkg::*; #(
    parameter int unsigned MAX_SEGMENTS = 64,
    parameter int unsigned HEADER_BYTES = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [ADDR_W-1:0]   request_bytes,
    input  logic [ADDR_W-1:0]   address,
    output logic                done,
    output logic [ADDR_W-1:0]   payload_address,
    output logic [STATUS_W-1:0] status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_data
);
    logic [ADDR_W-1:0] pool_bytes_reg;
    logic              q_valid, q_pop, back_idle;
    bfha_cmd_t         q_cmd;

    // config register always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_bytes_reg <= ADDR_W'(1048576);
        end
        else if (cfg_valid)
        begin
            pool_bytes_reg <= cfg_data;
        end
    end

    bfha_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .request_bytes(request_bytes), .address(address),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .back_idle(back_idle)
    );

    bfha_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .HEADER_BYTES(HEADER_BYTES)) u_back (
        .clk(clk), .rst_n(rst_n), .pool_bytes(pool_bytes_reg),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop), .idle(back_idle),
        .done(done), .payload_address(payload_address), .status(status)
    );
endmodule
